@@ hdl/i128u_pkg.sv @@
`default_nettype none
package i128u_pkg;
  localparam int unsigned DataW = 128;
  localparam int unsigned CmdW = 3;
  localparam int unsigned StagesDef = DataW;

  localparam logic [CmdW-1:0] CMD_SHL  = 3'd0;
  localparam logic [CmdW-1:0] CMD_ASHR = 3'd1;
  localparam logic [CmdW-1:0] CMD_LSHR = 3'd2;
  localparam logic [CmdW-1:0] CMD_MUL  = 3'd3;
  localparam logic [CmdW-1:0] CMD_SDIV = 3'd4;
  localparam logic [CmdW-1:0] CMD_UDIV = 3'd5;
  localparam logic [CmdW-1:0] CMD_SMOD = 3'd6;
  localparam logic [CmdW-1:0] CMD_UMOD = 3'd7;

  typedef struct packed {
    logic               vld;
    logic               is_div;
    logic               want_rem;
    logic               neg_q;
    logic               neg_r;
    logic               dz;
    logic [DataW-1:0]   num;
    logic [DataW-1:0]   den;
    logic [DataW-1:0]   rem;
    logic [DataW-1:0]   res;
  } cell_t;
endpackage
`default_nettype wire

@@ hdl/i128u_cell.sv @@
`default_nettype none
module i128u_cell
  import i128u_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   en,
  input  cell_t d_in,
  output cell_t d_out
);
  cell_t q_r, q_nxt;
  logic [DataW:0] sh;
  logic [DataW:0] df;

  always_comb begin
    q_nxt = d_in;
    sh = {d_in.rem, d_in.num[BIT]};
    df = sh - {1'b0, d_in.den};
    if (d_in.is_div) begin
      if (!df[DataW]) begin
        q_nxt.rem = df[DataW-1:0];
        q_nxt.res[BIT] = 1'b1;
      end else begin
        q_nxt.rem = sh[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule
`default_nettype wire

@@ hdl/int128_shift_mul_div_unit_core.sv @@
// 128-bit integer unit: shifts, low-128 multiply, signed/unsigned divide and remainder.
// in_*: one command beat per cycle unless stalled; out_* carries one result beat each.
// The block is a pipeline: an entry stage (shifts, multiply partial products, operand
// sign fix-up), a chain of STAGES restoring-division cells (one quotient bit per cell),
// and an exit stage (sign fix-up and result select). Every command passes the whole
// chain; throughput is one beat per cycle unless the output stalls.
// The multiply is formed from 32x32 partial products registered in the entry stage;
// their sum is taken into the first cell.
// Reset empties the pipeline. While a beat waits at the output and out_tready is low,
// the whole pipeline holds and in_tready drops; bubbles inside are not closed up.
// Zero divisor gives result 0 and div_zero high.
`default_nettype none
module int128_shift_mul_div_unit_core
  import i128u_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [263:0] in_tdata,   // cmd[2:0], a_low, a_high, b_low, b_high, pad[4:0]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [135:0] out_tdata   // result_low, result_high, div_zero, pad[6:0]
);
  localparam int unsigned STAGES = StagesDef;

  logic [CmdW-1:0]  cmd;
  logic [DataW-1:0] a, b, a_abs, b_abs, shres;
  logic [63:0]      amt;
  logic             sgn, na, nb, big, dz;
  logic             en;
  logic [6:0]       s;

  function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
    return 64'(x) * 64'(y);
  endfunction

  assign cmd = in_tdata[2:0];
  assign a   = {in_tdata[130:67], in_tdata[66:3]};
  assign b   = {in_tdata[258:195], in_tdata[194:131]};
  assign amt = in_tdata[194:131];

  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  // entry stage: partial products registered
  logic [63:0]  pp_r [0:9];
  logic [63:0]  pp_nxt [0:9];
  logic         mul_r;
  cell_t        ent_r, ent_nxt;

  always_comb begin
    big = amt >= 64'(DataW);
    s   = amt[6:0];
    sgn = (cmd == CMD_SDIV) || (cmd == CMD_SMOD);
    na  = sgn && a[DataW-1];
    nb  = sgn && b[DataW-1];
    a_abs = na ? -a : a;
    b_abs = nb ? -b : b;
    dz  = (b == '0);
    case (cmd)
      CMD_SHL:  shres = big ? '0 : (a << s);
      CMD_ASHR: shres = big ? {DataW{a[DataW-1]}} : DataW'($signed(a) >>> s);
      CMD_LSHR: shres = big ? '0 : (a >> s);
      default:  shres = '0;
    endcase
    pp_nxt[0] = mul32(a[31:0],   b[31:0]);
    pp_nxt[1] = mul32(a[31:0],   b[63:32]);
    pp_nxt[2] = mul32(a[63:32],  b[31:0]);
    pp_nxt[3] = mul32(a[31:0],   b[95:64]);
    pp_nxt[4] = mul32(a[63:32],  b[63:32]);
    pp_nxt[5] = mul32(a[95:64],  b[31:0]);
    pp_nxt[6] = mul32(a[31:0],   b[127:96]);
    pp_nxt[7] = mul32(a[63:32],  b[95:64]);
    pp_nxt[8] = mul32(a[95:64],  b[63:32]);
    pp_nxt[9] = mul32(a[127:96], b[31:0]);
    ent_nxt = '0;
    ent_nxt.vld      = in_tvalid;
    ent_nxt.is_div   = cmd[2] && !dz;
    ent_nxt.want_rem = cmd[1];
    ent_nxt.neg_q    = na ^ nb;
    ent_nxt.neg_r    = na;
    ent_nxt.dz       = cmd[2] && dz;
    ent_nxt.num      = a_abs;
    ent_nxt.den      = b_abs;
    ent_nxt.res      = shres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else if (en) begin
      ent_r   <= ent_nxt;
      mul_r   <= (cmd == CMD_MUL);
      pp_r    <= pp_nxt;
    end
  end

  // finish multiply: sum partial products by weight
  cell_t ch [0:STAGES];
  cell_t ch0;
  logic [DataW-1:0] mres;
  always_comb begin
    mres = {64'd0, pp_r[0]}
         + {32'd0, pp_r[1], 32'd0} + {32'd0, pp_r[2], 32'd0}
         + {pp_r[3], 64'd0} + {pp_r[4], 64'd0} + {pp_r[5], 64'd0}
         + {pp_r[6][31:0], 96'd0} + {pp_r[7][31:0], 96'd0}
         + {pp_r[8][31:0], 96'd0} + {pp_r[9][31:0], 96'd0};
    ch0 = ent_r;
    if (mul_r) begin
      ch0.res = mres;
    end
  end

  assign ch[0] = ch0;

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_cell
      i128u_cell #(.BIT(STAGES - 1 - g)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(en), .d_in(ch[g]), .d_out(ch[g+1])
      );
    end
  endgenerate

  logic [DataW-1:0] out_res;
  cell_t lst;
  always_comb begin
    lst = ch[STAGES];
    if (lst.dz) begin
      out_res = '0;
    end else if (!lst.is_div) begin
      out_res = lst.res;
    end else if (lst.want_rem) begin
      out_res = lst.neg_r ? -lst.rem : lst.rem;
    end else begin
      out_res = lst.neg_q ? -lst.res : lst.res;
    end
  end

  logic [DataW-1:0] ores_r;
  logic             odz_r, ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r   <= lst.vld;
      ores_r <= out_res;
      odz_r  <= lst.dz;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, odz_r, ores_r};
endmodule
`default_nettype wire

@@ hdl/i128u_checker.sv @@
`default_nettype none
module i128u_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [135:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled beat changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[135:129] == 7'd0)
    else $error("pad bits set");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[127:0] == 128'd0)
    else $error("divide by zero with nonzero result");
endmodule

bind int128_shift_mul_div_unit_core i128u_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

@@ dv/tb_int128_shift_mul_div_unit_core.sv @@
`default_nettype none
module tb_int128_shift_mul_div_unit_core;
  import i128u_pkg::*;

  localparam int unsigned NumRandom = 1900;
  localparam int unsigned Latency = StagesDef + 2;
  localparam logic [127:0] MinVal = {1'b1, 127'd0};
  localparam logic [127:0] MaxVal = {1'b0, {127{1'b1}}};
  localparam logic [127:0] AllOnes = {128{1'b1}};

  typedef struct packed {
    logic [63:0] res_lo;
    logic [63:0] res_hi;
    logic        dz;
  } alu_res_t;

  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [127:0]    a;
    logic [127:0]    b;
    logic            known;
    alu_res_t        res;
  } vec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [263:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;

  alu_res_t pending_res[$];
  bit       failed = 1'b0;
  bit       busy_phase = 1'b0;

  int128_shift_mul_div_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic alu_res_t alu_predict(logic [CmdW-1:0] cmd, logic [127:0] a,
                                           logic [127:0] b);
    alu_res_t     r;
    logic [63:0]  amt;
    logic [127:0] v;
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] q;
    logic [127:0] m;
    logic         na;
    logic         nb;
    logic         sgn;
    amt = b[63:0];
    v = '0;
    r.dz = 1'b0;
    case (cmd)
      CMD_SHL: v = (amt < 128) ? a << amt[6:0] : '0;
      CMD_ASHR: v = (amt < 128) ? 128'($signed(a) >>> amt[6:0]) : {128{a[127]}};
      CMD_LSHR: v = (amt < 128) ? a >> amt[6:0] : '0;
      CMD_MUL: v = a * b;
      default: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else begin
          sgn = (cmd == CMD_SDIV) || (cmd == CMD_SMOD);
          na = sgn && a[127];
          nb = sgn && b[127];
          ua = na ? -a : a;
          ub = nb ? -b : b;
          q = ua / ub;
          m = ua % ub;
          if (cmd == CMD_SDIV || cmd == CMD_UDIV) v = (na != nb) ? -q : q;
          else v = na ? -m : m;
        end
      end
    endcase
    r.res_lo = v[63:0];
    r.res_hi = v[127:64];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 128'($urandom_range(0, 40));
      1: return -128'($urandom_range(1, 40));
      2: return {64'd0, rand64()};
      3: return {{64{1'b1}}, rand64()};
      4: return 128'(rand64() >> $urandom_range(0, 63));
      5: begin
        case ($urandom_range(0, 3))
          0: return MinVal;
          1: return MaxVal;
          2: return AllOnes;
          default: return '0;
        endcase
      end
      default: return {rand64(), rand64()};
    endcase
  endfunction

  function automatic logic [127:0] rand_amount();
    case ($urandom_range(0, 5))
      0: return {rand64(), rand64()};
      1: return {rand64(), 64'($urandom_range(0, 127))};
      2: return 128'($urandom_range(120, 200));
      default: return 128'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_beat(logic [CmdW-1:0] cmd, logic [127:0] a, logic [127:0] b,
                           logic known, alu_res_t res);
    int unsigned gap;
    gap = busy_phase ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, b[127:64], b[63:0], a[127:64], a[63:0], cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_res.push_back(known ? res : alu_predict(cmd, a, b));
  endtask

  vec_t directed[] = '{
    '{CMD_SHL,  128'h1, 128'd127, 1'b1, '{64'd0, 64'h8000_0000_0000_0000, 1'b0}},
    '{CMD_SHL,  AllOnes, 128'd128, 1'b1, '{64'd0, 64'd0, 1'b0}},
    '{CMD_SHL,  AllOnes, {64'd5, 64'd0}, 1'b1, '{'1, '1, 1'b0}},
    '{CMD_ASHR, MinVal, 128'd128, 1'b1, '{'1, '1, 1'b0}},
    '{CMD_ASHR, MaxVal, {64'd0, {64{1'b1}}}, 1'b1, '{64'd0, 64'd0, 1'b0}},
    '{CMD_ASHR, MinVal, 128'd127, 1'b1, '{'1, '1, 1'b0}},
    '{CMD_ASHR, MinVal, 128'd0, 1'b0, '0},
    '{CMD_LSHR, AllOnes, 128'd127, 1'b1, '{64'd1, 64'd0, 1'b0}},
    '{CMD_LSHR, AllOnes, 128'd200, 1'b1, '{64'd0, 64'd0, 1'b0}},
    '{CMD_LSHR, AllOnes, 128'd64, 1'b0, '0},
    '{CMD_MUL,  AllOnes, AllOnes, 1'b1, '{64'd1, 64'd0, 1'b0}},
    '{CMD_MUL,  MaxVal, MinVal, 1'b0, '0},
    '{CMD_SDIV, MinVal, AllOnes, 1'b1, '{64'd0, 64'h8000_0000_0000_0000, 1'b0}},
    '{CMD_SMOD, MinVal, AllOnes, 1'b1, '{64'd0, 64'd0, 1'b0}},
    '{CMD_SDIV, 128'd7, '0, 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{CMD_UDIV, AllOnes, '0, 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{CMD_SMOD, MinVal, '0, 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{CMD_UMOD, MaxVal, '0, 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{CMD_SDIV, -128'd7, 128'd2, 1'b0, '0},
    '{CMD_SMOD, -128'd7, 128'd2, 1'b0, '0},
    '{CMD_SMOD, 128'd7, -128'd2, 1'b0, '0},
    '{CMD_UDIV, AllOnes, 128'd1, 1'b1, '{'1, '1, 1'b0}},
    '{CMD_UMOD, AllOnes, MinVal, 1'b0, '0},
    '{CMD_UDIV, 128'd5, AllOnes, 1'b1, '{64'd0, 64'd0, 1'b0}}
  };

  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got.res_lo = out_tdata[63:0];
      got.res_hi = out_tdata[127:64];
      got.dz = out_tdata[128];
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result lo=%h hi=%h dz=%b", $time,
                 got.res_lo, got.res_hi, got.dz);
        failed = 1'b1;
      end else begin
        exp_res = pending_res.pop_front();
        if (got.res_lo !== exp_res.res_lo) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   exp_res.res_lo, got.res_lo);
          failed = 1'b1;
        end
        if (got.res_hi !== exp_res.res_hi) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   exp_res.res_hi, got.res_hi);
          failed = 1'b1;
        end
        if (got.dz !== exp_res.dz) begin
          $display("%0t: div_zero expected %b actual %b", $time, exp_res.dz, got.dz);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = busy_phase ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [CmdW-1:0] cmd;
    logic [127:0]    a;
    logic [127:0]    b;
    int unsigned     drain;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_beat(directed[i].cmd, directed[i].a, directed[i].b, directed[i].known,
                directed[i].res);
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 150 == 0) busy_phase = ($urandom_range(0, 2) == 0);
      cmd = CmdW'($urandom_range(0, 7));
      a = rand_operand();
      b = (cmd <= CMD_LSHR) ? rand_amount() :
          ($urandom_range(0, 9) == 0) ? 128'd0 : rand_operand();
      send_beat(cmd, a, b, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    busy_phase = 1'b0;
    drain = 0;
    while (pending_res.size() != 0) begin
      drain++;
      @(posedge clk);
    end
    repeat (Latency + 20) @(posedge clk);
    if (!failed) begin
      $display("** int128_shift_mul_div_unit_core: PASSED **");
    end else begin
      $display("** int128_shift_mul_div_unit_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** int128_shift_mul_div_unit_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hdl/i128u_pkg.sv
hdl/i128u_cell.sv
hdl/int128_shift_mul_div_unit_core.sv
hdl/i128u_checker.sv
dv/tb_int128_shift_mul_div_unit_core.sv
